### rtl/sfd_pkg.sv
// ============================================================================
// sfd_pkg: shared types and constants of the SSTP frame demultiplexer
// Result word layout, channel and status codes, and the result burst that
// the parser hands to the output stage.
// ============================================================================
package sfd_pkg;

   // Largest number of results that one received byte can cause.
   localparam int MAX_RESULTS = 6;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] channel_type;
   typedef logic [1:0] status_type;
   typedef logic [2:0] count_type;

   localparam channel_type CH_NONE    = 2'd0;
   localparam channel_type CH_PPP     = 2'd1;
   localparam channel_type CH_CONTROL = 2'd2;
   localparam channel_type CH_ECHO    = 2'd3;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FRAME_ERR = 2'd1;
   localparam status_type ST_SHORT     = 2'd2;

   typedef struct packed {
      channel_type channel;
      byte_type    data;
      logic        valid;
      logic        first;
      logic        last;
      status_type  status;
   } result_type;

   // Results caused by one byte, slot 0 goes out first.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      count_type                    count;
   } burst_type;

   function automatic result_type mk_result(input channel_type ch, input byte_type d,
                                            input logic v, input logic f,
                                            input logic l, input status_type st);
      result_type r;
      r.channel = ch;
      r.data    = d;
      r.valid   = v;
      r.first   = f;
      r.last    = l;
      r.status  = st;
      return r;
   endfunction

endpackage

### rtl/sfd_in_buf.sv
// ============================================================================
// sfd_in_buf: input register with skid stage
// Holds the next received byte for the parser and keeps the ready signal
// on the request side a pure register output.
// ============================================================================
module sfd_in_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sfd_pkg::byte_type req_tdata,
   input  logic              consume,
   output logic              byte_valid,
   output sfd_pkg::byte_type byte_data
);
   import sfd_pkg::*;

   logic     main_valid_ff, main_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   byte_type main_data_ff, main_data_in;
   byte_type skid_data_ff, skid_data_in;
   logic     take;

   assign req_tready = !skid_valid_ff;
   assign take       = req_tvalid && !skid_valid_ff;
   assign byte_valid = main_valid_ff;
   assign byte_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // The skid word moves up once the main word has been used.
         if (consume) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (take) begin
         if (!main_valid_ff || consume) begin
            main_valid_in = 1'b1;
            main_data_in  = req_tdata;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = req_tdata;
         end
      end else if (consume) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

### rtl/sfd_parse.sv
// ============================================================================
// sfd_parse: SSTP deframer and LCP echo recognizer
// Tracks the frame state and, in one pass per byte, forms every result that
// the byte causes as a burst of up to six result words.
// ============================================================================
module sfd_parse #(
   parameter int LENGTH_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  sfd_pkg::byte_type  rx_byte,
   input  sfd_pkg::byte_type  cfg_version,
   input  logic               cfg_echo_en,
   input  logic               cfg_strip,
   output sfd_pkg::burst_type burst
);
   import sfd_pkg::*;

   localparam int L              = LENGTH_BITS;
   localparam int HOLD_DEPTH     = 6;
   localparam int HEADER_LEN     = 4;
   localparam int PREFIX_LEN     = 2;
   localparam int MIN_DATA_LEN   = 2;
   localparam int ECHO_MIN_LEN   = 10;
   localparam int ECHO_ZERO_SPAN = 10;
   localparam int LCP_MIN_LEN    = 8;
   localparam int LCP_PROTO_LEN  = 2;

   localparam byte_type PPP_ADDRESS  = 8'hFF;
   localparam byte_type PPP_CONTROL  = 8'h03;
   localparam byte_type LCP_PROTO_HI = 8'hC0;
   localparam byte_type LCP_PROTO_LO = 8'h21;
   localparam byte_type LCP_ECHO_REQ = 8'h09;
   localparam byte_type LCP_ECHO_REP = 8'h0A;

   typedef enum logic [7:0] {
      MODE_HEADER  = 8'b0000_0001,
      MODE_CONTROL = 8'b0000_0010,
      MODE_PREFIX1 = 8'b0000_0100,
      MODE_PREFIX2 = 8'b0000_1000,
      MODE_HOLD    = 8'b0001_0000,
      MODE_PPP     = 8'b0010_0000,
      MODE_ECHO    = 8'b0100_0000,
      MODE_DISCARD = 8'b1000_0000
   } route_mode_type;

   logic           halted_ff, halted_in;
   logic [1:0]     hdr_cnt_ff, hdr_cnt_in;
   byte_type       hdr_store_ff [3];
   byte_type       hdr_store_in [3];
   logic [L-1:0]   plen_ff, plen_in;
   logic [L-1:0]   ppos_ff, ppos_in;
   route_mode_type mode_ff, mode_in;
   logic           stripped_ff, stripped_in;
   byte_type       hold_ff [HOLD_DEPTH];
   byte_type       hold_in [HOLD_DEPTH];
   logic [2:0]     hcnt_ff, hcnt_in;
   logic [L-1:0]   elen_ff, elen_in;
   logic           echo_en_ff, echo_en_in;

   logic [15:0]    hdr_word;
   logic [L-1:0]   hdr_len;
   logic [L-1:0]   new_plen;
   logic [L-1:0]   slen;
   logic [L-1:0]   idx;
   logic [15:0]    lcp_len;
   logic [16:0]    lcp_total;
   logic [L:0]     pos_next;
   logic           feed_en;
   route_mode_type feed_mode;
   logic [L-1:0]   feed_idx;
   logic           hold_fail;

   // A PPP data result at payload index i of a payload of length sl.
   function automatic result_type ppp_result(input byte_type d, input logic [L-1:0] i,
                                             input logic [L-1:0] sl);
      return mk_result(CH_PPP, d, 1'b1, i == '0,
                       ({1'b0, i} + (L+1)'(1)) == {1'b0, sl}, ST_OK);
   endfunction

   // Echo recognition needs a payload long enough to hold a full request.
   function automatic route_mode_type start_mode(input logic en, input logic [L-1:0] sl);
      return (en && sl >= L'(ECHO_MIN_LEN)) ? MODE_HOLD : MODE_PPP;
   endfunction

   assign hdr_word  = {hdr_store_ff[2], rx_byte};
   assign hdr_len   = hdr_word[L-1:0];
   assign new_plen  = hdr_len - L'(HEADER_LEN);
   assign slen      = plen_ff - (stripped_ff ? L'(PREFIX_LEN) : '0);
   assign idx       = ppos_ff - (stripped_ff ? L'(PREFIX_LEN) : '0);
   assign lcp_len   = {hold_ff[4], rx_byte};
   assign lcp_total = {1'b0, lcp_len} + 17'(LCP_PROTO_LEN);
   assign pos_next  = {1'b0, ppos_ff} + (L+1)'(1);

   always_comb begin
      halted_in    = halted_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      hdr_store_in = hdr_store_ff;
      plen_in      = plen_ff;
      ppos_in      = ppos_ff;
      mode_in      = mode_ff;
      stripped_in  = stripped_ff;
      hold_in      = hold_ff;
      hcnt_in      = hcnt_ff;
      elen_in      = elen_ff;
      echo_en_in   = echo_en_ff;
      burst        = '0;
      feed_en      = 1'b0;
      feed_mode    = mode_ff;
      feed_idx     = idx;
      hold_fail    = 1'b0;

      if (go && !halted_ff) begin
         if (mode_ff == MODE_HEADER) begin
            if (hdr_cnt_ff != 2'd3) begin
               hdr_store_in[hdr_cnt_ff] = rx_byte;
               hdr_cnt_in               = hdr_cnt_ff + 2'd1;
            end else begin
               hdr_cnt_in = 2'd0;
               if (hdr_store_ff[0] != cfg_version || hdr_len < L'(HEADER_LEN)) begin
                  halted_in       = 1'b1;
                  burst.res[0]    = mk_result(CH_NONE, 8'h00, 1'b0, 1'b0, 1'b0,
                                              ST_FRAME_ERR);
                  burst.count     = 3'd1;
               end else begin
                  plen_in     = new_plen;
                  ppos_in     = '0;
                  stripped_in = 1'b0;
                  hcnt_in     = 3'd0;
                  elen_in     = '0;
                  echo_en_in  = cfg_echo_en;
                  if (hdr_store_ff[1][0]) begin
                     if (new_plen == '0) begin
                        burst.res[0] = mk_result(CH_CONTROL, 8'h00, 1'b0, 1'b1, 1'b1,
                                                 ST_OK);
                        burst.count  = 3'd1;
                     end else begin
                        mode_in = MODE_CONTROL;
                     end
                  end else if (new_plen < L'(MIN_DATA_LEN)) begin
                     burst.res[0] = mk_result(CH_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ST_SHORT);
                     burst.count  = 3'd1;
                     mode_in      = (new_plen == '0) ? MODE_HEADER : MODE_DISCARD;
                  end else if (cfg_strip) begin
                     mode_in = MODE_PREFIX1;
                  end else begin
                     mode_in = start_mode(cfg_echo_en, new_plen);
                  end
               end
            end
         end else begin
            case (mode_ff)
               MODE_CONTROL: begin
                  burst.res[0] = mk_result(CH_CONTROL, rx_byte, 1'b1, ppos_ff == '0,
                                           pos_next == {1'b0, plen_ff}, ST_OK);
                  burst.count  = 3'd1;
               end
               MODE_PREFIX1: begin
                  if (rx_byte == PPP_ADDRESS) begin
                     mode_in = MODE_PREFIX2;
                  end else begin
                     feed_en   = 1'b1;
                     feed_mode = start_mode(echo_en_ff, plen_ff);
                     feed_idx  = '0;
                     mode_in   = feed_mode;
                  end
               end
               MODE_PREFIX2: begin
                  hcnt_in = 3'd0;
                  if (rx_byte == PPP_CONTROL) begin
                     stripped_in = 1'b1;
                     if (plen_ff - L'(PREFIX_LEN) < L'(MIN_DATA_LEN)) begin
                        burst.res[0] = mk_result(CH_NONE, 8'h00, 1'b0, 1'b0, 1'b0,
                                                 ST_SHORT);
                        burst.count  = 3'd1;
                        mode_in      = MODE_DISCARD;
                     end else begin
                        mode_in = start_mode(echo_en_ff, plen_ff - L'(PREFIX_LEN));
                     end
                  end else begin
                     // A lone FF is payload: it can never open an echo request,
                     // so both bytes go straight out as PPP data.
                     burst.res[0] = ppp_result(PPP_ADDRESS, '0, plen_ff);
                     burst.res[1] = ppp_result(rx_byte, L'(1), plen_ff);
                     burst.count  = 3'd2;
                     mode_in      = MODE_PPP;
                  end
               end
               MODE_HOLD, MODE_PPP, MODE_ECHO: begin
                  feed_en = 1'b1;
               end
               default: begin
               end
            endcase

            if (feed_en) begin
               case (feed_mode)
                  MODE_PPP: begin
                     burst.res[0] = ppp_result(rx_byte, feed_idx, slen);
                     burst.count  = 3'd1;
                  end
                  MODE_HOLD: begin
                     if (hcnt_ff >= 3'(HOLD_DEPTH)) begin
                        mode_in      = MODE_PPP;
                        burst.res[0] = ppp_result(rx_byte, feed_idx, slen);
                        burst.count  = 3'd1;
                     end else begin
                        hold_in[hcnt_ff] = rx_byte;
                        if (hcnt_ff == 3'd0 && rx_byte != LCP_PROTO_HI) hold_fail = 1'b1;
                        if (hcnt_ff == 3'd1 && rx_byte != LCP_PROTO_LO) hold_fail = 1'b1;
                        if (hcnt_ff == 3'd2 && rx_byte != LCP_ECHO_REQ) hold_fail = 1'b1;
                        if (hcnt_ff == 3'(HOLD_DEPTH - 1)) begin
                           if (lcp_len < 16'(LCP_MIN_LEN) || lcp_total > 17'(slen)) begin
                              hold_fail = 1'b1;
                           end
                        end
                        if (hold_fail) begin
                           // Release everything held as ordinary PPP data.
                           for (int i = 0; i < HOLD_DEPTH; i++) begin
                              if (3'(i) < hcnt_ff) begin
                                 burst.res[i] = ppp_result(hold_ff[i], L'(i), slen);
                              end else if (3'(i) == hcnt_ff) begin
                                 burst.res[i] = ppp_result(rx_byte, L'(i), slen);
                              end
                           end
                           burst.count = hcnt_ff + 3'd1;
                           hcnt_in     = 3'd0;
                           mode_in     = MODE_PPP;
                        end else if (hcnt_ff == 3'(HOLD_DEPTH - 1)) begin
                           // Valid echo request: answer with a reply header.
                           elen_in      = lcp_total[L-1:0];
                           mode_in      = MODE_ECHO;
                           hcnt_in      = 3'd0;
                           burst.res[0] = mk_result(CH_ECHO, LCP_PROTO_HI, 1'b1, 1'b1,
                                                    1'b0, ST_OK);
                           burst.res[1] = mk_result(CH_ECHO, LCP_PROTO_LO, 1'b1, 1'b0,
                                                    1'b0, ST_OK);
                           burst.res[2] = mk_result(CH_ECHO, LCP_ECHO_REP, 1'b1, 1'b0,
                                                    1'b0, ST_OK);
                           burst.res[3] = mk_result(CH_ECHO, hold_ff[3], 1'b1, 1'b0,
                                                    1'b0, ST_OK);
                           burst.res[4] = mk_result(CH_ECHO, hold_ff[4], 1'b1, 1'b0,
                                                    1'b0, ST_OK);
                           burst.res[5] = mk_result(CH_ECHO, rx_byte, 1'b1, 1'b0,
                                                    1'b0, ST_OK);
                           burst.count  = 3'(MAX_RESULTS);
                        end else begin
                           hcnt_in = hcnt_ff + 3'd1;
                        end
                     end
                  end
                  MODE_ECHO: begin
                     // The magic number is zeroed and the tail past the LCP
                     // length is dropped.
                     if (feed_idx < elen_ff) begin
                        burst.res[0] = mk_result(CH_ECHO,
                                          (feed_idx < L'(ECHO_ZERO_SPAN)) ? 8'h00 : rx_byte,
                                          1'b1, 1'b0,
                                          ({1'b0, feed_idx} + (L+1)'(1)) == {1'b0, elen_ff},
                                          ST_OK);
                        burst.count  = 3'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (pos_next >= {1'b0, plen_ff}) begin
               mode_in    = MODE_HEADER;
               hdr_cnt_in = 2'd0;
               ppos_in    = '0;
            end else begin
               ppos_in = pos_next[L-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff   <= 1'b0;
         hdr_cnt_ff  <= 2'd0;
         plen_ff     <= '0;
         ppos_ff     <= '0;
         mode_ff     <= MODE_HEADER;
         stripped_ff <= 1'b0;
         hcnt_ff     <= 3'd0;
         elen_ff     <= '0;
         echo_en_ff  <= 1'b1;
      end else begin
         halted_ff   <= halted_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         plen_ff     <= plen_in;
         ppos_ff     <= ppos_in;
         mode_ff     <= mode_in;
         stripped_ff <= stripped_in;
         hcnt_ff     <= hcnt_in;
         elen_ff     <= elen_in;
         echo_en_ff  <= echo_en_in;
      end
      hdr_store_ff <= hdr_store_in;
      hold_ff      <= hold_in;
   end

endmodule

### rtl/sfd_out_burst.sv
// ============================================================================
// sfd_out_burst: result burst register
// Takes the burst formed for one byte and shifts it out one result word per
// accepted handshake on the result channel.
// ============================================================================
module sfd_out_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sfd_pkg::burst_type  burst,
   output logic                drained,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output sfd_pkg::result_type head,
   output logic                head_last
);
   import sfd_pkg::*;

   result_type slot_ff [MAX_RESULTS];
   result_type slot_in [MAX_RESULTS];
   count_type  left_ff, left_in;
   logic       pop;

   assign pop        = (left_ff != '0) && rsp_tready;
   assign drained    = (left_ff == '0) || (left_ff == 3'd1 && rsp_tready);
   assign rsp_tvalid = left_ff != '0;
   assign head       = slot_ff[0];
   assign head_last  = left_ff == 3'd1;

   always_comb begin
      slot_in = slot_ff;
      left_in = left_ff;
      if (load && burst.count != '0) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_in[i] = burst.res[i];
         end
         left_in = burst.count;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      slot_ff <= slot_in;
   end

endmodule

### rtl/sstp_frame_demux_lcp_echo.sv
// ============================================================================
// sstp_frame_demux_lcp_echo: SSTP receive deframer with LCP echo answering
// Splits a decrypted byte stream into SSTP frames, routes control and PPP
// payloads, and turns LCP echo requests into echo replies inline.
// ============================================================================
//
// Channel   Dir  Word contents
// req_*     in   tdata[7:0] received byte
// rsp_*     out  tdata: out byte, byte valid, frame first, frame last;
//                tuser: channel, status; tlast: last result of a byte
// csr_*     in   write enable, register index, write data
//
// A byte goes from the input register through the parser into the burst
// register, so a new byte is taken every cycle while each byte yields at most one
// result and the result channel is ready. A byte with more results, such as an
// echo reply or a released hold, keeps the next byte out until its last result
// is taken. The first result word is offered from the burst register. Reset is
// synchronous; a result stall fills the skid, then drops ready.
//
module sstp_frame_demux_lcp_echo #(
   parameter int LENGTH_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // Received byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Demultiplexed results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] byte_valid,
                                    // [9] frame_first, [10] frame_last, rest zero
   output logic [3:0]  rsp_tuser,   // [1:0] channel, [3:2] status
   output logic        rsp_tlast,   // run_last
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);
   import sfd_pkg::*;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [1:0] CSR_ECHO_REPLY_EN    = 2'd1;
   localparam logic [1:0] CSR_STRIP_ADDR_CTRL  = 2'd2;

   byte_type   version_ff, version_in;
   logic       echo_en_ff, echo_en_in;
   logic       strip_ff, strip_in;

   logic       byte_valid;
   byte_type   byte_data;
   logic       drained;
   logic       go;
   burst_type  burst;
   result_type head;
   logic       head_last;

   // The settings are sampled by the parser when a header completes, so a
   // frame keeps the values that were in place at its start.
   always_comb begin
      version_in = version_ff;
      echo_en_in = echo_en_ff;
      strip_in   = strip_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_EXPECTED_VERSION: version_in = csr_wdata;
            CSR_ECHO_REPLY_EN:    echo_en_in = csr_wdata[0];
            CSR_STRIP_ADDR_CTRL:  strip_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'h10;
         echo_en_ff <= 1'b1;
         strip_ff   <= 1'b1;
      end else begin
         version_ff <= version_in;
         echo_en_ff <= echo_en_in;
         strip_ff   <= strip_in;
      end
   end

   // A byte moves into the parser only when the burst register will be empty
   // at the next edge, so a burst is never overwritten.
   assign go = byte_valid && drained;

   sfd_in_buf u_in_buf (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .consume    (go),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   sfd_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .rx_byte     (byte_data),
      .cfg_version (version_ff),
      .cfg_echo_en (echo_en_ff),
      .cfg_strip   (strip_ff),
      .burst       (burst)
   );

   sfd_out_burst u_out_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (go),
      .burst      (burst),
      .drained    (drained),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head),
      .head_last  (head_last)
   );

   // Result word packing.
   assign rsp_tdata = {5'b0, head.last, head.first, head.valid, head.data};
   assign rsp_tuser = {head.status, head.channel};
   assign rsp_tlast = head_last;

endmodule
